/* rtl/core/flc_pkg.sv */
// flc_pkg: shared types, constants and codes for the fuel level conditioner
// used by flc_divider and fuel_level_conditioner; no dependencies
package flc_pkg;

	localparam int unsigned SAMPLES_PER_READING = 10;
	localparam int unsigned CNT_W = $clog2(SAMPLES_PER_READING + 1);

	// group average by reciprocal multiply, exact for any 16-bit sum
	localparam int unsigned AVG_SHIFT = 16 + $clog2(SAMPLES_PER_READING);
	localparam int unsigned AVG_RW    = 17;
	localparam int unsigned AVG_PW    = 16 + AVG_RW;
	localparam logic [AVG_RW-1:0] AVG_RECIP =
		AVG_RW'(((64'd1 << AVG_SHIFT) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

	// shared divider sizing
	localparam int unsigned DIV_DW = 24;
	localparam int unsigned DIV_VW = 17;
	localparam int unsigned DIV_CW = $clog2(DIV_DW + 1);

	localparam int unsigned CFG_IW = 3;
	localparam int unsigned CFG_DW = 24;

	typedef enum logic [CFG_IW-1:0] {
		CFG_LITRES_GAIN  = 3'd0,
		CFG_ADC_CLAMP    = 3'd1,
		CFG_LITRE_OFFSET = 3'd2,
		CFG_TANK_CAP     = 3'd3,
		CFG_LOW_THRESH   = 3'd4,
		CFG_REARM_LEVEL  = 3'd5
	} cfg_index_t;

	localparam logic [23:0] RST_LITRES_GAIN  = 24'd32013;
	localparam logic [11:0] RST_ADC_CLAMP    = 12'd4094;
	localparam logic [15:0] RST_LITRE_OFFSET = 16'd209;
	localparam logic [15:0] RST_TANK_CAP     = 16'd2000;
	localparam logic [6:0]  RST_LOW_THRESH   = 7'd50;
	localparam logic [6:0]  RST_REARM_LEVEL  = 7'd55;

	localparam logic [6:0] PCT_FULL = 7'd100;

	typedef struct packed {
		logic [11:0] adc_sample;
		logic        link_up;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] level_litres;
		logic [6:0]  level_percent;
		logic        sensor_off;
		logic        low_level;
		logic        alert_pulse;
	} out_beat_t;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_DW-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_SCALE,
		ST_OFFSET,
		ST_PCT_START,
		ST_PCT_WAIT,
		ST_OUT
	} flc_state_t;

endpackage

/* rtl/core/fuel_level_conditioner.sv */
// fuel_level_conditioner: averages sensor samples into fuel litres, percent and alarm
// depends on flc_pkg and flc_divider
//
// Usage: every input beat carries one 12-bit sensor sample and the link state.
// Samples are summed in groups of SAMPLES_PER_READING; only the beat that
// closes a group yields an output beat; the others are only added to the sum.
// A closing beat runs through a small sequencer around one shift-subtract
// divider: the group average by reciprocal multiply, scaling and offset,
// divider start, the 24-step percent division with its done cycle and the
// output load into the output register. in_stall stays high from the
// closing beat until the sequencer returns to idle. A zero average skips
// scaling and the percent division; a zero capacity skips the division.
// The output register lets the next group collect while a result waits; if a
// new group closes while the receiver still stalls, the block holds that
// reading and keeps in_stall high until the output register is taken.
// Configuration is to be written by the user through cfg_we/cfg_index/cfg_data
// only while idle; the block itself does not enforce this. Reset clears the
// sums, held litres, held percent and alert state and loads register defaults.
module fuel_level_conditioner (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  flc_pkg::in_beat_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output flc_pkg::out_beat_t             out_data,
	input  logic                           cfg_we,
	input  logic [flc_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [flc_pkg::CFG_DW-1:0]     cfg_data
);
	import flc_pkg::*;

	// configuration
	logic [23:0]        gain_q;
	logic [11:0]        clamp_q;
	logic signed [15:0] offset_q;
	logic [15:0]        cap_q;
	logic [6:0]         low_thr_q;
	logic [6:0]         rearm_q;

	// accumulation and held state
	logic [15:0]      sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      held_litres_q;
	logic [6:0]       held_pct_q;
	logic             alert_sent_q;

	// work registers of one reading
	flc_state_t  state_q, state_d;
	logic        link_q;
	logic [15:0] grp_sum_q;
	logic        off_q;
	logic [11:0] avg_q;
	logic [20:0] raw_q;
	logic [15:0] lit_q;

	out_beat_t out_q;
	logic      out_valid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic             in_acc;
	logic [15:0]      sum_n;
	logic [CNT_W-1:0] cnt_n;
	logic             closing;
	logic             out_free;

	logic [AVG_PW-1:0]  avg_prod;
	logic [15:0]        avg_full;
	logic [35:0]        prod;
	logic [36:0]        prod_rnd;
	logic signed [22:0] lit_s;
	logic [23:0]        pct_num;
	logic [6:0]         pct_new;
	logic               low;
	logic               pulse;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign sum_n     = sum_q + {4'b0, in_data.adc_sample};
	assign cnt_n     = cnt_q + 1'b1;
	assign closing   = (cnt_n >= CNT_W'(SAMPLES_PER_READING));
	assign out_free  = !out_valid_q || !out_stall;

	assign avg_prod  = {{AVG_RW{1'b0}}, grp_sum_q} * {16'b0, AVG_RECIP};
	assign avg_full  = 16'(avg_prod >> AVG_SHIFT);
	assign prod      = {24'b0, avg_q} * {12'b0, gain_q};
	assign prod_rnd  = {1'b0, prod} + 37'd32768;
	assign lit_s     = $signed({2'b0, raw_q}) + 23'(offset_q);
	assign pct_num   = ({8'b0, lit_q} * 24'd200) + {8'b0, cap_q};
	assign pct_new   = (div_rsp.quotient > DIV_DW'(PCT_FULL)) ? PCT_FULL
	                   : div_rsp.quotient[6:0];

	assign low   = (held_pct_q < low_thr_q);
	assign pulse = low && !alert_sent_q && link_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = pct_num;
		div_req.divisor  = {1'b0, cap_q} << 1;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && closing) begin
					state_d = ST_AVG;
				end
			end
			ST_AVG: begin
				state_d = (avg_full == '0) ? ST_OUT : ST_SCALE;
			end
			ST_SCALE: begin
				state_d = ST_OFFSET;
			end
			ST_OFFSET: begin
				state_d = ST_PCT_START;
			end
			ST_PCT_START: begin
				if (cap_q == '0) begin
					state_d = ST_OUT;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_PCT_WAIT;
				end
			end
			ST_PCT_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	flc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= RST_LITRES_GAIN;
			clamp_q   <= RST_ADC_CLAMP;
			offset_q  <= RST_LITRE_OFFSET;
			cap_q     <= RST_TANK_CAP;
			low_thr_q <= RST_LOW_THRESH;
			rearm_q   <= RST_REARM_LEVEL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LITRES_GAIN:  gain_q    <= cfg_data[23:0];
				CFG_ADC_CLAMP:    clamp_q   <= cfg_data[11:0];
				CFG_LITRE_OFFSET: offset_q  <= cfg_data[15:0];
				CFG_TANK_CAP:     cap_q     <= cfg_data[15:0];
				CFG_LOW_THRESH:   low_thr_q <= cfg_data[6:0];
				CFG_REARM_LEVEL:  rearm_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q         <= '0;
			cnt_q         <= '0;
			held_litres_q <= '0;
			held_pct_q    <= '0;
			alert_sent_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				if (closing) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
				end
			end
			if (state_q == ST_PCT_START && cap_q == '0) begin
				held_litres_q <= lit_q;
				held_pct_q    <= '0;
			end
			if (state_q == ST_PCT_WAIT && div_rsp.done) begin
				held_litres_q <= lit_q;
				held_pct_q    <= pct_new;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				// hysteresis: fire once below threshold, re-arm at rearm level
				if (pulse) begin
					alert_sent_q <= 1'b1;
				end else if (!low && held_pct_q >= rearm_q) begin
					alert_sent_q <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && closing) begin
			link_q    <= in_data.link_up;
			grp_sum_q <= sum_n;
		end
		if (state_q == ST_AVG) begin
			off_q <= (avg_full == '0);
			avg_q <= (avg_full > {4'b0, clamp_q}) ? clamp_q : avg_full[11:0];
		end
		if (state_q == ST_SCALE) begin
			raw_q <= prod_rnd[36:16];
		end
		if (state_q == ST_OFFSET) begin
			if (lit_s < 0) begin
				lit_q <= '0;
			end else if (lit_s[21:0] > {6'b0, cap_q}) begin
				lit_q <= cap_q;
			end else begin
				lit_q <= lit_s[15:0];
			end
		end
		if (state_q == ST_OUT && out_free) begin
			out_q.level_litres  <= held_litres_q;
			out_q.level_percent <= held_pct_q;
			out_q.sensor_off    <= off_q;
			out_q.low_level     <= low;
			out_q.alert_pulse   <= pulse;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/core/flc_divider.sv */
// flc_divider: restoring shift-subtract divider, one quotient bit per cycle
// depends on flc_pkg for the request and response structs
module flc_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  flc_pkg::div_req_t req,
	output flc_pkg::div_rsp_t rsp
);
	import flc_pkg::*;

	logic [DIV_VW-1:0] rem_q;
	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW-1:0] divisor_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIV_VW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_DW-1]};
	assign fits  = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			// dividend bits shift out the top as quotient bits shift in
			if (fits) begin
				rem_q <= DIV_VW'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[DIV_VW-1:0];
			end
			quo_q <= {quo_q[DIV_DW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* bench/fuel_level_conditioner_test.sv */
// fuel_level_conditioner_test: self-checking bench for the fuel level conditioner
// drives sample beats, rewrites registers between phases, checks readings against a predictor
// depends on flc_pkg and the fuel_level_conditioner rtl
module fuel_level_conditioner_test;
	timeunit 1ns;
	timeprecision 1ps;

	import flc_pkg::*;

	typedef longint unsigned u64_t;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [11:0] sample;
		logic        link;
		logic        typed;
		out_beat_t   reading;
	} opening_row_t;

	localparam int unsigned PHASES      = 16;
	localparam int unsigned PHASE_ITEMS = 86;
	localparam int unsigned SETTLE      = 80;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned OPEN_ROWS   = 30;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_beat_t out_data;
	logic      cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	// predictor copy of the registers
	logic [23:0]        gain_q16;
	logic [11:0]        adc_clamp;
	logic signed [15:0] offset_l;
	logic [15:0]        capacity;
	logic [6:0]         low_pct;
	logic [6:0]         rearm_pct;

	// predictor copy of the state
	logic [15:0] run_sum;
	int unsigned run_cnt;
	logic [15:0] held_l;
	logic [6:0]  held_p;
	logic        alert_out;

	out_beat_t   readings_due[$];
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned strays = 0;
	int unsigned quiet_cycles = 0;
	int          level_now = 2048;

	opening_row_t opening_rows[OPEN_ROWS];

	fuel_level_conditioner i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic bit predict_reading(input in_beat_t b, output out_beat_t rd);
		logic [11:0] avg;
		u64_t        raw;
		u64_t        pct;
		u64_t        cap;
		longint      lit;
		logic        off;
		logic        low;
		logic        pulse;
		rd = '0;
		run_sum = run_sum + 16'(b.adc_sample);
		run_cnt = run_cnt + 1;
		if (run_cnt < SAMPLES_PER_READING) return 1'b0;
		avg = 12'(run_sum / SAMPLES_PER_READING);
		run_sum = '0;
		run_cnt = 0;
		off = (avg == '0);
		pulse = 1'b0;
		if (!off) begin
			if (avg > adc_clamp) avg = adc_clamp;
			raw = (u64_t'(avg) * gain_q16 + 64'd32768) >> 16;
			lit = longint'(raw) + longint'(offset_l);
			cap = capacity;
			if (lit < 0) lit = 0;
			if (u64_t'(lit) > cap) lit = longint'(cap);
			if (cap == 0) begin
				pct = 0;
			end else begin
				pct = (u64_t'(lit) * 200 + cap) / (cap * 2);
				if (pct > 100) pct = 100;
			end
			held_l = 16'(lit);
			held_p = 7'(pct);
		end
		low = (held_p < low_pct);
		if (low) begin
			if (!alert_out && b.link_up) begin
				pulse = 1'b1;
				alert_out = 1'b1;
			end
		end else if (held_p >= rearm_pct) begin
			alert_out = 1'b0;
		end
		rd.level_litres  = held_l;
		rd.level_percent = held_p;
		rd.sensor_off    = off;
		rd.low_level     = low;
		rd.alert_pulse   = pulse;
		return 1'b1;
	endfunction

	// entered and left at a falling edge
	task automatic send_sample(input in_beat_t b, input logic typed, input out_beat_t typed_rd);
		out_beat_t rd;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (predict_reading(b, rd)) readings_due.push_back(typed ? typed_rd : rd);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_LITRES_GAIN:  gain_q16  = val[23:0];
			CFG_ADC_CLAMP:    adc_clamp = val[11:0];
			CFG_LITRE_OFFSET: offset_l  = val[15:0];
			CFG_TANK_CAP:     capacity  = val[15:0];
			CFG_LOW_THRESH:   low_pct   = val[6:0];
			CFG_REARM_LEVEL:  rearm_pct = val[6:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_settings(input int unsigned phase);
		logic [23:0] gain;
		logic [11:0] clamp;
		logic [15:0] offs;
		logic [15:0] cap;
		logic [6:0]  thr;
		logic [6:0]  rearm;
		int unsigned r;
		case (phase)
			1: begin
				gain = 24'hFFFFFF; clamp = 12'd4095; offs = 16'h7FFF;
				cap = 16'hFFFF; thr = 7'd100; rearm = 7'd100;
			end
			2: begin
				gain = 24'd0; clamp = 12'd1; offs = 16'h8000;
				cap = 16'd0; thr = 7'd0; rearm = 7'd0;
			end
			3: begin
				gain = 24'd32013; clamp = 12'd4095; offs = 16'h8000;
				cap = 16'd1; thr = 7'd127; rearm = 7'd127;
			end
			4: begin
				gain = 24'd65536; clamp = 12'd4095; offs = -16'sd1000;
				cap = 16'd4095; thr = 7'd30; rearm = 7'd60;
			end
			5: begin
				gain = 24'd16384; clamp = 12'd2048; offs = 16'd0;
				cap = 16'd1000; thr = 7'd100; rearm = 7'd0;
			end
			default: begin
				cap = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300))
				                                  : 16'($urandom_range(1, 65535));
				// gain near capacity per full-scale count, sometimes anything
				gain = 24'((u64_t'(cap) * 65536) / 4094) ^ 24'($urandom_range(0, 255));
				if ($urandom_range(0, 4) == 0) gain = 24'($urandom);
				clamp = ($urandom_range(0, 1) == 0) ? 12'd4095 - 12'($urandom_range(0, 3))
				                                    : 12'($urandom_range(1, 4095));
				offs = 16'($urandom_range(0, 400)) - 16'd200;
				if ($urandom_range(0, 4) == 0) offs = 16'($urandom);
				thr = 7'($urandom_range(0, 100));
				r = thr + $urandom_range(0, 10);
				rearm = (r > 127) ? 7'd127 : 7'(r);
				if ($urandom_range(0, 5) == 0) begin
					thr   = 7'($urandom_range(0, 127));
					rearm = 7'($urandom_range(0, 127));
				end
			end
		endcase
		write_reg(CFG_LITRES_GAIN, CFG_DW'(gain));
		write_reg(CFG_ADC_CLAMP, CFG_DW'(clamp));
		write_reg(CFG_LITRE_OFFSET, CFG_DW'(offs));
		write_reg(CFG_TANK_CAP, CFG_DW'(cap));
		write_reg(CFG_LOW_THRESH, CFG_DW'(thr));
		write_reg(CFG_REARM_LEVEL, CFG_DW'(rearm));
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 69; stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 69; end
			IDLE_BOTH: begin send_idle_pct = 17; stall_pct = 17; end
			default: ;
		endcase
	endtask

	// one group of samples shaped like a real reading, all near zero, all full scale, or a burst of noise
	task automatic send_group(output int unsigned sent);
		in_beat_t    b;
		int unsigned kind;
		int unsigned n;
		int          s;
		kind = $urandom_range(0, 9);
		n = SAMPLES_PER_READING - run_cnt;
		if (kind == 0) n = $urandom_range(1, SAMPLES_PER_READING);
		level_now = level_now + int'($urandom_range(0, 800)) - 400;
		if (level_now < 0) level_now = 0;
		if (level_now > 4095) level_now = 4095;
		for (int unsigned k = 0; k < n; k++) begin
			case (kind)
				0: s = int'($urandom_range(0, 4095));
				1: s = ($urandom_range(0, 4) == 0) ? 1 : 0;
				2: s = 4095;
				default: s = level_now + int'($urandom_range(0, 40)) - 20;
			endcase
			if (s < 0) s = 0;
			if (s > 4095) s = 4095;
			b.adc_sample = 12'(s);
			b.link_up = ($urandom_range(0, 3) != 0);
			send_sample(b, 1'b0, '0);
		end
		sent = n;
	endtask

	// readings leave at a rising edge with valid high and stall low
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (readings_due.size() == 0) begin
				strays++;
				if (strays + mismatches <= 10)
					$display("unexpected reading: litres %0d pct %0d off %b low %b alert %b",
						out_data.level_litres, out_data.level_percent, out_data.sensor_off,
						out_data.low_level, out_data.alert_pulse);
			end else begin
				want = readings_due.pop_front();
				if (out_data.level_litres !== want.level_litres ||
						out_data.level_percent !== want.level_percent ||
						out_data.sensor_off !== want.sensor_off ||
						out_data.low_level !== want.low_level ||
						out_data.alert_pulse !== want.alert_pulse) begin
					mismatches++;
					if (strays + mismatches <= 10) begin
						$write("reading mismatch: exp litres %0d pct %0d off %b low %b alert %b,",
							want.level_litres, want.level_percent, want.sensor_off,
							want.low_level, want.alert_pulse);
						$display(" got litres %0d pct %0d off %b low %b alert %b",
							out_data.level_litres, out_data.level_percent, out_data.sensor_off,
							out_data.low_level, out_data.alert_pulse);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[fuel_level_conditioner] ERROR");
			$finish;
		end
	end

	initial begin
		in_beat_t b;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		gain_q16  = RST_LITRES_GAIN;
		adc_clamp = RST_ADC_CLAMP;
		offset_l  = RST_LITRE_OFFSET;
		capacity  = RST_TANK_CAP;
		low_pct   = RST_LOW_THRESH;
		rearm_pct = RST_REARM_LEVEL;
		run_sum   = '0;
		run_cnt   = 0;
		held_l    = '0;
		held_p    = '0;
		alert_out = 1'b0;

		// sensor off at reset: zero held level is low, link up on the closing beat
		for (int i = 0; i < 10; i++)
			opening_rows[i] = '{12'd0, 1'(i % 2), 1'b0, '0};
		opening_rows[9] = '{12'd0, 1'b1, 1'b1, '{16'd0, 7'd0, 1'b1, 1'b1, 1'b1}};
		// full scale: clamped average, litres clamped to capacity, alert re-armed
		for (int i = 10; i < 20; i++)
			opening_rows[i] = '{12'd4095, 1'(i % 2), 1'b0, '0};
		opening_rows[19] = '{12'd4095, 1'b0, 1'b1, '{16'd2000, 7'd100, 1'b0, 1'b0, 1'b0}};
		// sensor off again: held full level comes back
		for (int i = 20; i < 30; i++)
			opening_rows[i] = '{12'd0, 1'b1, 1'b0, '0};
		opening_rows[29] = '{12'd0, 1'b1, 1'b1, '{16'd2000, 7'd100, 1'b1, 1'b0, 1'b0}};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(IDLE_NONE);
		foreach (opening_rows[i]) begin
			b.adc_sample = opening_rows[i].sample;
			b.link_up    = opening_rows[i].link;
			send_sample(b, opening_rows[i].typed, opening_rows[i].reading);
		end

		for (int unsigned p = 0; p < PHASES; p++) begin
			int unsigned start_cnt;
			if (p != 0) begin
				in_valid <= 1'b0;
				while (readings_due.size() != 0) @(negedge clk);
				repeat (SETTLE) @(negedge clk);
				load_settings(p);
				@(negedge clk);
			end
			set_idling(idle_mode_t'(p % 4));
			start_cnt = 0;
			while (start_cnt < PHASE_ITEMS) begin
				int unsigned sent;
				send_group(sent);
				start_cnt += sent;
			end
		end

		in_valid <= 1'b0;
		while (readings_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && strays == 0 && readings_due.size() == 0)
			$display("[fuel_level_conditioner] OK");
		else
			$display("[fuel_level_conditioner] ERROR");
		$finish;
	end

endmodule
